### hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal text to float32 unit
// Float constants, command/status structs, state enums and digit conversion.
// ----------------------------------------------------------------------------
package dtf_pkg;

	localparam int SIG_W = 50;
	localparam int EXP_W = 12;

	localparam logic [31:0] F_ZERO = 32'h0000_0000;
	localparam logic [31:0] F_ONE  = 32'h3F80_0000;
	localparam logic [31:0] F_TEN  = 32'h4120_0000;
	localparam logic [31:0] F_INF  = 32'h7F80_0000;
	localparam logic [31:0] F_QNAN = 32'h7FC0_0000;

	localparam logic [5:0] EXP_MAX = 6'd63;

	typedef enum logic [1:0] {
		FOP_ADD,
		FOP_MUL,
		FOP_DIV
	} fop_t;

	typedef enum logic [3:0] {
		U_INT_MUL,
		U_INT_ADD,
		U_FR_MUL,
		U_FR_ADD,
		U_DV_MUL,
		U_QDIV,
		U_RADD,
		U_PMUL,
		U_SMUL,
		U_SDIV
	} uop_t;

	typedef enum logic [2:0] {
		PH_BLANK,
		PH_SIGNED,
		PH_INT,
		PH_FRAC,
		PH_EXPSIGN,
		PH_EXPDIG,
		PH_STOP
	} ph_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_INT_MUL,
		C_INT_ADD,
		C_FR_MUL,
		C_FR_ADD,
		C_DV_MUL,
		C_FIN,
		C_QDIV,
		C_RADD,
		C_PMUL,
		C_SCALE,
		C_LOAD,
		C_OUT
	} ctl_state_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_NORM,
		F_DONE
	} fpu_state_t;

	typedef struct packed {
		logic       start;
		uop_t       uop;
		logic [3:0] digit;
		logic       clear;
		logic       load_zero;
		logic       load_res;
		logic       negate;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	function automatic logic [31:0] digit_to_float(input logic [3:0] d);
		logic [31:0] f;
		case (d)
			4'd0: f = 32'h0000_0000;
			4'd1: f = 32'h3F80_0000;
			4'd2: f = 32'h4000_0000;
			4'd3: f = 32'h4040_0000;
			4'd4: f = 32'h4080_0000;
			4'd5: f = 32'h40A0_0000;
			4'd6: f = 32'h40C0_0000;
			4'd7: f = 32'h40E0_0000;
			4'd8: f = 32'h4100_0000;
			4'd9: f = 32'h4110_0000;
			default: f = 32'h0000_0000;
		endcase
		return f;
	endfunction

endpackage

### hw/rtl/dtf_fpu.sv
// ----------------------------------------------------------------------------
// dtf_fpu: iterative single-precision add / multiply / divide
// Nonnegative operands only. Division is restoring, one bit per cycle;
// normalization shifts by one or eight bits per cycle, then rounds to nearest even.
// ----------------------------------------------------------------------------
module dtf_fpu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dtf_pkg::fop_t op,
	input  logic [31:0]   a,
	input  logic [31:0]   b,
	output logic          done,
	output logic [31:0]   y
);

	dtf_pkg::fpu_state_t st_q, st_nx;

	logic [dtf_pkg::SIG_W-1:0]        sig_q;
	logic signed [dtf_pkg::EXP_W-1:0] e_q;
	logic                             stk_q;
	logic [24:0]                      rem_q;
	logic [23:0]                      mb_q;
	logic [5:0]                       cnt_q;
	logic [31:0]                      y_q;

	logic [23:0] ma, mb;
	logic [7:0]  ea, eb;
	logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic        spec;
	logic [31:0] spec_y;

	assign ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
	assign mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
	assign ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
	assign eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];

	assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	assign b_zero = (b[30:0] == 31'd0);

	always_comb begin
		spec   = 1'b0;
		spec_y = dtf_pkg::F_QNAN;
		case (op)
			dtf_pkg::FOP_ADD: begin
				if (a_nan || b_nan) begin
					spec = 1'b1;
				end else if (a_inf || b_inf) begin
					spec   = 1'b1;
					spec_y = dtf_pkg::F_INF;
				end
			end
			dtf_pkg::FOP_MUL: begin
				if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
					spec = 1'b1;
				end else if (a_inf || b_inf) begin
					spec   = 1'b1;
					spec_y = dtf_pkg::F_INF;
				end
			end
			dtf_pkg::FOP_DIV: begin
				if (a_nan || b_nan || (a_inf && b_inf)) begin
					spec = 1'b1;
				end else if (b_inf) begin
					spec   = 1'b1;
					spec_y = dtf_pkg::F_ZERO;
				end else if (a_inf) begin
					spec   = 1'b1;
					spec_y = dtf_pkg::F_INF;
				end
			end
			default: spec = 1'b0;
		endcase
	end

	// add: align the smaller operand, collect shifted-out bits as sticky
	logic        swap;
	logic [23:0] m_big, m_sml;
	logic [7:0]  e_big, e_dif;
	logic [99:0] al_w;
	logic [dtf_pkg::SIG_W-1:0] add_sig;
	logic        add_stk;

	assign swap    = (ea < eb);
	assign m_big   = swap ? mb : ma;
	assign m_sml   = swap ? ma : mb;
	assign e_big   = swap ? eb : ea;
	assign e_dif   = swap ? (eb - ea) : (ea - eb);
	assign al_w    = {1'b0, m_sml, 75'd0} >> e_dif;
	assign add_sig = {1'b0, m_big, 25'd0} + al_w[99:50];
	assign add_stk = |al_w[49:0];

	logic [47:0] prod;
	assign prod = ma * mb;

	// divide step
	logic        q_bit;
	logic [24:0] r_sub;
	assign q_bit = (rem_q >= {1'b0, mb_q});
	assign r_sub = q_bit ? (rem_q - {1'b0, mb_q}) : rem_q;

	// rounding
	logic [23:0] m24, m_res;
	logic [24:0] m25;
	logic        g_bit, s_bit, rnd_up, carry;
	logic signed [dtf_pkg::EXP_W-1:0] e_fin;
	logic [31:0] packed_y;
	logic        norm_fin;

	assign m24    = sig_q[49:26];
	assign g_bit  = sig_q[25];
	assign s_bit  = (|sig_q[24:0]) | stk_q;
	assign rnd_up = g_bit & (s_bit | m24[0]);
	assign m25    = {1'b0, m24} + {24'd0, rnd_up};
	assign carry  = m25[24];
	assign m_res  = carry ? m25[24:1] : m25[23:0];
	assign e_fin  = e_q + $signed({{(dtf_pkg::EXP_W-1){1'b0}}, carry});

	always_comb begin
		if (e_fin >= 12'sd255) begin
			packed_y = dtf_pkg::F_INF;
		end else begin
			packed_y = {1'b0, (m_res[23] ? e_fin[7:0] : 8'd0), m_res[22:0]};
		end
	end

	assign norm_fin = (sig_q == '0) ||
		((e_q > 12'sd0) && (sig_q[dtf_pkg::SIG_W-1] || (e_q == 12'sd1)));

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			dtf_pkg::F_IDLE: begin
				if (start) begin
					if (spec) st_nx = dtf_pkg::F_DONE;
					else if (op == dtf_pkg::FOP_DIV) st_nx = dtf_pkg::F_DIV;
					else st_nx = dtf_pkg::F_NORM;
				end
			end
			dtf_pkg::F_DIV: begin
				if (cnt_q == 6'd0) st_nx = dtf_pkg::F_NORM;
			end
			dtf_pkg::F_NORM: begin
				if (norm_fin) st_nx = dtf_pkg::F_DONE;
			end
			dtf_pkg::F_DONE: st_nx = dtf_pkg::F_IDLE;
			default: st_nx = dtf_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == dtf_pkg::F_DONE);
		y    = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dtf_pkg::F_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			dtf_pkg::F_IDLE: begin
				if (start) begin
					if (spec) begin
						y_q <= spec_y;
					end else begin
						case (op)
							dtf_pkg::FOP_ADD: begin
								sig_q <= add_sig;
								stk_q <= add_stk;
								e_q   <= $signed({4'd0, e_big}) + 12'sd1;
							end
							dtf_pkg::FOP_MUL: begin
								sig_q <= {prod, 2'b00};
								stk_q <= 1'b0;
								e_q   <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
							end
							default: begin
								sig_q <= '0;
								stk_q <= 1'b0;
								rem_q <= {1'b0, ma};
								mb_q  <= mb;
								cnt_q <= 6'd48;
								e_q   <= $signed({4'd0, ea}) - $signed({4'd0, eb}) + 12'sd128;
							end
						endcase
					end
				end
			end
			dtf_pkg::F_DIV: begin
				sig_q <= {sig_q[dtf_pkg::SIG_W-2:0], q_bit};
				rem_q <= {r_sub[23:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) stk_q <= (r_sub != 25'd0);
			end
			dtf_pkg::F_NORM: begin
				if (sig_q == '0) begin
					y_q <= dtf_pkg::F_ZERO;
				end else if (e_q < 12'sd1) begin
					if (e_q < -12'sd7) begin
						sig_q <= {8'd0, sig_q[dtf_pkg::SIG_W-1:8]};
						stk_q <= stk_q | (|sig_q[7:0]);
						e_q   <= e_q + 12'sd8;
					end else begin
						sig_q <= {1'b0, sig_q[dtf_pkg::SIG_W-1:1]};
						stk_q <= stk_q | sig_q[0];
						e_q   <= e_q + 12'sd1;
					end
				end else if (!sig_q[dtf_pkg::SIG_W-1] && (e_q > 12'sd1)) begin
					if ((sig_q[dtf_pkg::SIG_W-1:dtf_pkg::SIG_W-8] == 8'd0) && (e_q > 12'sd8)) begin
						sig_q <= {sig_q[dtf_pkg::SIG_W-9:0], 8'd0};
						e_q   <= e_q - 12'sd8;
					end else begin
						sig_q <= {sig_q[dtf_pkg::SIG_W-2:0], 1'b0};
						e_q   <= e_q - 12'sd1;
					end
				end else begin
					y_q <= packed_y;
				end
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/dtf_dp.sv
// ----------------------------------------------------------------------------
// dtf_dp: float accumulators and result register
// Decodes each micro-op to FPU operands and a destination accumulator.
// ----------------------------------------------------------------------------
module dtf_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  dtf_pkg::cmd_t   cmd,
	output dtf_pkg::sts_t   sts,
	output logic [31:0]     res
);

	logic [31:0] mant_q, frac_q, dvs_q, pow_q, tmp_q, res_q;
	logic [31:0] opa, opb, fy, dig_f;
	dtf_pkg::fop_t fop;
	logic fdone;

	assign dig_f = dtf_pkg::digit_to_float(cmd.digit);

	always_comb begin
		fop = dtf_pkg::FOP_MUL;
		opa = mant_q;
		opb = dtf_pkg::F_TEN;
		unique case (cmd.uop)
			dtf_pkg::U_INT_MUL: begin fop = dtf_pkg::FOP_MUL; opa = mant_q; opb = dtf_pkg::F_TEN; end
			dtf_pkg::U_INT_ADD: begin fop = dtf_pkg::FOP_ADD; opa = mant_q; opb = dig_f; end
			dtf_pkg::U_FR_MUL:  begin fop = dtf_pkg::FOP_MUL; opa = frac_q; opb = dtf_pkg::F_TEN; end
			dtf_pkg::U_FR_ADD:  begin fop = dtf_pkg::FOP_ADD; opa = frac_q; opb = dig_f; end
			dtf_pkg::U_DV_MUL:  begin fop = dtf_pkg::FOP_MUL; opa = dvs_q;  opb = dtf_pkg::F_TEN; end
			dtf_pkg::U_QDIV:    begin fop = dtf_pkg::FOP_DIV; opa = frac_q; opb = dvs_q; end
			dtf_pkg::U_RADD:    begin fop = dtf_pkg::FOP_ADD; opa = mant_q; opb = tmp_q; end
			dtf_pkg::U_PMUL:    begin fop = dtf_pkg::FOP_MUL; opa = pow_q;  opb = dtf_pkg::F_TEN; end
			dtf_pkg::U_SMUL:    begin fop = dtf_pkg::FOP_MUL; opa = tmp_q;  opb = pow_q; end
			dtf_pkg::U_SDIV:    begin fop = dtf_pkg::FOP_DIV; opa = tmp_q;  opb = pow_q; end
			default: ;
		endcase
	end

	dtf_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (fop),
		.a      (opa),
		.b      (opb),
		.done   (fdone),
		.y      (fy)
	);

	assign sts.done = fdone;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_q <= dtf_pkg::F_ZERO;
			frac_q <= dtf_pkg::F_ZERO;
			dvs_q  <= dtf_pkg::F_ONE;
			pow_q  <= dtf_pkg::F_ONE;
		end else if (cmd.clear) begin
			mant_q <= dtf_pkg::F_ZERO;
			frac_q <= dtf_pkg::F_ZERO;
			dvs_q  <= dtf_pkg::F_ONE;
			pow_q  <= dtf_pkg::F_ONE;
		end else if (fdone) begin
			case (cmd.uop) inside
				dtf_pkg::U_INT_MUL, dtf_pkg::U_INT_ADD: mant_q <= fy;
				dtf_pkg::U_FR_MUL, dtf_pkg::U_FR_ADD:   frac_q <= fy;
				dtf_pkg::U_DV_MUL:                      dvs_q  <= fy;
				dtf_pkg::U_PMUL:                        pow_q  <= fy;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fdone && (cmd.uop inside {dtf_pkg::U_QDIV, dtf_pkg::U_RADD,
				dtf_pkg::U_SMUL, dtf_pkg::U_SDIV})) begin
			tmp_q <= fy;
		end
		if (cmd.load_zero) begin
			res_q <= dtf_pkg::F_ZERO;
		end else if (cmd.load_res) begin
			if ((tmp_q[30:23] == 8'hFF) && (tmp_q[22:0] != 23'd0)) res_q <= dtf_pkg::F_QNAN;
			else res_q <= tmp_q ^ {cmd.negate, 31'd0};
		end
	end

endmodule

### hw/rtl/dtf_ctrl.sv
// ----------------------------------------------------------------------------
// dtf_ctrl: character parser and micro-op sequencer
// Tracks parse phase, sign and exponent; issues FPU micro-ops per character
// and the closing sequence on the last character.
// ----------------------------------------------------------------------------
module dtf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_char,
	input  logic          in_cvalid,
	input  logic          in_last,
	output logic          out_valid,
	input  logic          out_ready,
	output dtf_pkg::cmd_t cmd,
	input  dtf_pkg::sts_t sts
);

	dtf_pkg::ctl_state_t state_q, state_nx;
	dtf_pkg::ph_t        ph_q, ph_nx;
	logic       neg_q, neg_nx, eneg_q, eneg_nx, eseen_q, eseen_nx;
	logic [5:0] exp_q, exp_nx, cnt_q;
	logic [3:0] digit_q;
	logic       last_q, pend_q;
	logic       do_int, do_frac, is_op, accept;

	logic c_blank, c_digit, c_dot, c_e, c_plus, c_minus, num_path;
	logic [9:0] e10;
	logic [3:0] c_val;

	assign c_blank = (in_char == 8'd32) || (in_char == 8'd13) || (in_char == 8'd10) ||
		(in_char == 8'd9);
	assign c_digit = (in_char >= 8'd48) && (in_char <= 8'd57);
	assign c_dot   = (in_char == 8'd46);
	assign c_e     = (in_char == 8'd101) || (in_char == 8'd69);
	assign c_plus  = (in_char == 8'd43);
	assign c_minus = (in_char == 8'd45);
	assign c_val   = 4'(in_char - 8'd48);
	assign e10     = {1'b0, exp_q, 3'b000} + {3'b000, exp_q, 1'b0} + {6'd0, c_val};
	assign accept  = in_valid && in_ready;

	always_comb begin
		ph_nx    = ph_q;
		neg_nx   = neg_q;
		eneg_nx  = eneg_q;
		eseen_nx = eseen_q;
		exp_nx   = exp_q;
		do_int   = 1'b0;
		do_frac  = 1'b0;
		num_path = 1'b0;
		if (in_cvalid) begin
			case (ph_q) inside
				dtf_pkg::PH_BLANK: begin
					if (c_blank) ;
					else if (c_minus) begin neg_nx = 1'b1; ph_nx = dtf_pkg::PH_SIGNED; end
					else if (c_plus) ph_nx = dtf_pkg::PH_SIGNED;
					else num_path = 1'b1;
				end
				dtf_pkg::PH_SIGNED, dtf_pkg::PH_INT: num_path = 1'b1;
				dtf_pkg::PH_FRAC: begin
					if (c_digit) do_frac = 1'b1;
					else if (c_e) begin eseen_nx = 1'b1; ph_nx = dtf_pkg::PH_EXPSIGN; end
					else ph_nx = dtf_pkg::PH_STOP;
				end
				dtf_pkg::PH_EXPSIGN: begin
					if (c_minus) begin eneg_nx = 1'b1; ph_nx = dtf_pkg::PH_EXPDIG; end
					else if (c_plus) ph_nx = dtf_pkg::PH_EXPDIG;
					else if (c_digit) begin
						exp_nx = (e10 > {4'd0, dtf_pkg::EXP_MAX}) ? dtf_pkg::EXP_MAX : e10[5:0];
						ph_nx  = dtf_pkg::PH_EXPDIG;
					end else ph_nx = dtf_pkg::PH_STOP;
				end
				dtf_pkg::PH_EXPDIG: begin
					if (c_digit) begin
						exp_nx = (e10 > {4'd0, dtf_pkg::EXP_MAX}) ? dtf_pkg::EXP_MAX : e10[5:0];
					end else ph_nx = dtf_pkg::PH_STOP;
				end
				default: ;
			endcase
			if (num_path) begin
				if (c_digit) begin do_int = 1'b1; ph_nx = dtf_pkg::PH_INT; end
				else if (c_dot) ph_nx = dtf_pkg::PH_FRAC;
				else if (c_e) begin eseen_nx = 1'b1; ph_nx = dtf_pkg::PH_EXPSIGN; end
				else ph_nx = dtf_pkg::PH_STOP;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dtf_pkg::C_IDLE: begin
				if (accept) begin
					if (do_int) state_nx = dtf_pkg::C_INT_MUL;
					else if (do_frac) state_nx = dtf_pkg::C_FR_MUL;
					else if (in_last) state_nx = dtf_pkg::C_FIN;
				end
			end
			dtf_pkg::C_INT_MUL: if (sts.done) state_nx = dtf_pkg::C_INT_ADD;
			dtf_pkg::C_INT_ADD: if (sts.done) state_nx = last_q ? dtf_pkg::C_FIN : dtf_pkg::C_IDLE;
			dtf_pkg::C_FR_MUL:  if (sts.done) state_nx = dtf_pkg::C_FR_ADD;
			dtf_pkg::C_FR_ADD:  if (sts.done) state_nx = dtf_pkg::C_DV_MUL;
			dtf_pkg::C_DV_MUL:  if (sts.done) state_nx = last_q ? dtf_pkg::C_FIN : dtf_pkg::C_IDLE;
			dtf_pkg::C_FIN: begin
				if (ph_q == dtf_pkg::PH_BLANK || ph_q == dtf_pkg::PH_SIGNED) state_nx = dtf_pkg::C_OUT;
				else state_nx = dtf_pkg::C_QDIV;
			end
			dtf_pkg::C_QDIV: if (sts.done) state_nx = dtf_pkg::C_RADD;
			dtf_pkg::C_RADD: if (sts.done) state_nx = eseen_q ? dtf_pkg::C_PMUL : dtf_pkg::C_LOAD;
			dtf_pkg::C_PMUL: begin
				if (cnt_q == 6'd0) state_nx = dtf_pkg::C_SCALE;
			end
			dtf_pkg::C_SCALE: if (sts.done) state_nx = dtf_pkg::C_LOAD;
			dtf_pkg::C_LOAD: state_nx = dtf_pkg::C_OUT;
			dtf_pkg::C_OUT: if (out_ready) state_nx = dtf_pkg::C_IDLE;
			default: state_nx = dtf_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == dtf_pkg::C_IDLE);
		out_valid     = (state_q == dtf_pkg::C_OUT);
		is_op         = 1'b0;
		cmd.uop       = dtf_pkg::U_INT_MUL;
		cmd.digit     = digit_q;
		cmd.negate    = neg_q;
		cmd.clear     = (state_q == dtf_pkg::C_OUT) && out_ready;
		cmd.load_zero = (state_q == dtf_pkg::C_FIN) &&
			(ph_q == dtf_pkg::PH_BLANK || ph_q == dtf_pkg::PH_SIGNED);
		cmd.load_res  = (state_q == dtf_pkg::C_LOAD);
		unique case (state_q)
			dtf_pkg::C_INT_MUL: begin is_op = 1'b1; cmd.uop = dtf_pkg::U_INT_MUL; end
			dtf_pkg::C_INT_ADD: begin is_op = 1'b1; cmd.uop = dtf_pkg::U_INT_ADD; end
			dtf_pkg::C_FR_MUL:  begin is_op = 1'b1; cmd.uop = dtf_pkg::U_FR_MUL; end
			dtf_pkg::C_FR_ADD:  begin is_op = 1'b1; cmd.uop = dtf_pkg::U_FR_ADD; end
			dtf_pkg::C_DV_MUL:  begin is_op = 1'b1; cmd.uop = dtf_pkg::U_DV_MUL; end
			dtf_pkg::C_QDIV:    begin is_op = 1'b1; cmd.uop = dtf_pkg::U_QDIV; end
			dtf_pkg::C_RADD:    begin is_op = 1'b1; cmd.uop = dtf_pkg::U_RADD; end
			dtf_pkg::C_PMUL:    begin is_op = (cnt_q != 6'd0); cmd.uop = dtf_pkg::U_PMUL; end
			dtf_pkg::C_SCALE: begin
				is_op   = 1'b1;
				cmd.uop = eneg_q ? dtf_pkg::U_SDIV : dtf_pkg::U_SMUL;
			end
			default: ;
		endcase
		cmd.start = is_op && !pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtf_pkg::C_IDLE;
			ph_q    <= dtf_pkg::PH_BLANK;
			neg_q   <= 1'b0;
			eneg_q  <= 1'b0;
			eseen_q <= 1'b0;
			exp_q   <= 6'd0;
			cnt_q   <= 6'd0;
			last_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.start) pend_q <= 1'b1;
			else if (sts.done) pend_q <= 1'b0;
			if (accept) begin
				ph_q    <= ph_nx;
				neg_q   <= neg_nx;
				eneg_q  <= eneg_nx;
				eseen_q <= eseen_nx;
				exp_q   <= exp_nx;
				last_q  <= in_last;
			end
			if (state_q == dtf_pkg::C_FIN) cnt_q <= exp_q;
			else if (state_q == dtf_pkg::C_PMUL && sts.done) cnt_q <= cnt_q - 6'd1;
			if (cmd.clear) begin
				ph_q    <= dtf_pkg::PH_BLANK;
				neg_q   <= 1'b0;
				eneg_q  <= 1'b0;
				eseen_q <= 1'b0;
				exp_q   <= 6'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) digit_q <= c_val;
	end

	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while result pending");

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> pend_q) else $error("fpu done without issued request");

	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start) else $error("fpu started twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped under stall");

endmodule

### hw/rtl/decimal_text_to_float32_unit.sv
// ----------------------------------------------------------------------------
// decimal_text_to_float32_unit: streaming decimal text to float32 converter
// Parses one character per request; emits the float32 bits on the last one.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one ASCII character, s_tuser says whether a
// character is present, s_tlast closes the string. Output stream: m_tdata is
// the float32 bit pattern, one request per string.
// A character is accepted only while the unit is idle. Blanks, signs, dots and
// exponent characters leave the unit idle; an integer digit takes two FPU ops
// (multiply by ten, add digit), a fraction digit three, each through the shared
// iterative FPU before the next character is taken. After the last character:
// a 49-step restoring divide, an add and, with an exponent, one multiply per
// exponent count (up to 63) and a final multiply, or a divide for a negative
// exponent. Empty, blank-only or bare-sign strings skip the arithmetic: zero is
// loaded in C_FIN and presented from C_OUT. The result is held on m_tdata with
// m_tvalid high until m_tready; no new character is taken meanwhile. Reset
// returns the parser to blank skipping with cleared accumulators; no request is
// in flight after reset.
// ----------------------------------------------------------------------------
module decimal_text_to_float32_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tuser,   // [0] char_valid
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] value_bits
);

	dtf_pkg::cmd_t cmd;
	dtf_pkg::sts_t sts;

	dtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.in_cvalid (s_tuser),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dtf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.res    (m_tdata)
	);

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for decimal_text_to_float32_unit
// Streams decimal strings one character per request, predicts each float32 result
// with a bit-exact integer model of single-precision arithmetic or a fixed table
// value, and checks every output request against it under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_REQS  = 1750;

	typedef struct {
		logic [7:0]  chr;
		logic        has_chr;
		logic        is_last;
		bit          fixed;
		logic [31:0] fixed_val;
	} req_t;

	typedef struct {
		string       txt;
		bit          fixed;
		logic [31:0] val;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	logic [31:0] float_q[$];
	req_t        req_q[$];
	int          mismatch_cnt = 0;
	int          idle_cnt = 0;
	bit          stall_req = 0;

	// parser state of the predictor
	dtf_pkg::ph_t p_phase;
	logic        p_neg;
	logic        p_eneg;
	logic [31:0] p_mant;
	logic [31:0] p_frac;
	logic [31:0] p_divr;
	logic [5:0]  p_ecnt;
	logic        p_eseen;

	decimal_text_to_float32_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ---- single-precision arithmetic, round to nearest even ----
	function automatic bit f_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic bit f_inf(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] == 0;
	endfunction

	function automatic bit f_zero(logic [31:0] x);
		return x[30:0] == 0;
	endfunction

	function automatic void f_split(input logic [31:0] x, output logic [23:0] s, output int e);
		if (x[30:23] == 0) begin
			s = {1'b0, x[22:0]};
			e = -149;
		end else begin
			s = {1'b1, x[22:0]};
			e = int'(x[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] f_round(logic [319:0] sig, int e, bit sticky);
		int p, sh, ex;
		logic [319:0] q, rem, half;
		if (sig == 0)
			return dtf_pkg::F_ZERO;
		p = 319;
		while (!sig[p])
			p--;
		if (p + e > 127)
			return dtf_pkg::F_INF;
		sh = (p + e >= -126) ? p - 23 : -149 - e;
		if (sh > 300)
			return dtf_pkg::F_ZERO;
		if (sh > 0) begin
			q = sig >> sh;
			rem = sig & ((320'd1 << sh) - 1);
			half = 320'd1 << (sh - 1);
			if (rem > half || (rem == half && (sticky || q[0])))
				q = q + 1;
		end else begin
			q = sig << (-sh);
		end
		ex = e + sh;
		if (q[24]) begin
			q = q >> 1;
			ex++;
		end
		if (!q[23])
			return {9'd0, q[22:0]};
		if (ex + 150 >= 255)
			return dtf_pkg::F_INF;
		return {1'b0, 8'(ex + 150), q[22:0]};
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		logic [23:0] sa, sb;
		int ea, eb;
		if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b)))
			return dtf_pkg::F_QNAN;
		if (f_inf(a) || f_inf(b))
			return dtf_pkg::F_INF;
		if (f_zero(a) || f_zero(b))
			return dtf_pkg::F_ZERO;
		f_split(a, sa, ea);
		f_split(b, sb, eb);
		return f_round(320'(sa) * 320'(sb), ea + eb, 0);
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		logic [23:0] sa, sb;
		int ea, eb, m;
		if (f_nan(a) || f_nan(b))
			return dtf_pkg::F_QNAN;
		if (f_inf(a) || f_inf(b))
			return dtf_pkg::F_INF;
		if (f_zero(a))
			return b;
		if (f_zero(b))
			return a;
		f_split(a, sa, ea);
		f_split(b, sb, eb);
		m = ea < eb ? ea : eb;
		return f_round((320'(sa) << (ea - m)) + (320'(sb) << (eb - m)), m, 0);
	endfunction

	function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
		logic [23:0] sa, sb;
		int ea, eb;
		logic [319:0] num;
		if (f_nan(a) || f_nan(b) || (f_inf(a) && f_inf(b)) || (f_zero(a) && f_zero(b)))
			return dtf_pkg::F_QNAN;
		if (f_inf(a) || f_zero(b))
			return dtf_pkg::F_INF;
		if (f_inf(b) || f_zero(a))
			return dtf_pkg::F_ZERO;
		f_split(a, sa, ea);
		f_split(b, sb, eb);
		num = 320'(sa) << 80;
		return f_round(num / 320'(sb), ea - eb - 80, (num % 320'(sb)) != 0);
	endfunction

	// ---- text parser predictor ----
	function automatic void parser_clear();
		p_phase = dtf_pkg::PH_BLANK;
		p_neg = 0;
		p_eneg = 0;
		p_mant = dtf_pkg::F_ZERO;
		p_frac = dtf_pkg::F_ZERO;
		p_divr = dtf_pkg::F_ONE;
		p_ecnt = 0;
		p_eseen = 0;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void add_exp_digit(logic [7:0] c);
		int n;
		n = int'(p_ecnt) * 10 + int'(c - "0");
		p_ecnt = n > int'(dtf_pkg::EXP_MAX) ? dtf_pkg::EXP_MAX : 6'(n);
	endfunction

	function automatic void parse_char(logic [7:0] c);
		logic [3:0] d;
		d = 4'(c - "0");
		if (p_phase == dtf_pkg::PH_BLANK) begin
			if (c == " " || c == 8'd13 || c == 8'd10 || c == 8'd9)
				return;
			if (c == "-") begin
				p_neg = 1;
				p_phase = dtf_pkg::PH_SIGNED;
				return;
			end
			if (c == "+") begin
				p_phase = dtf_pkg::PH_SIGNED;
				return;
			end
		end
		case (p_phase) inside
			dtf_pkg::PH_BLANK, dtf_pkg::PH_SIGNED, dtf_pkg::PH_INT: begin
				if (is_digit(c)) begin
					p_mant = f_add(f_mul(p_mant, dtf_pkg::F_TEN), dtf_pkg::digit_to_float(d));
					p_phase = dtf_pkg::PH_INT;
				end else if (c == ".") begin
					p_phase = dtf_pkg::PH_FRAC;
				end else if (c == "e" || c == "E") begin
					p_eseen = 1;
					p_phase = dtf_pkg::PH_EXPSIGN;
				end else begin
					p_phase = dtf_pkg::PH_STOP;
				end
			end
			dtf_pkg::PH_FRAC: begin
				if (is_digit(c)) begin
					p_frac = f_add(f_mul(p_frac, dtf_pkg::F_TEN), dtf_pkg::digit_to_float(d));
					p_divr = f_mul(p_divr, dtf_pkg::F_TEN);
				end else if (c == "e" || c == "E") begin
					p_eseen = 1;
					p_phase = dtf_pkg::PH_EXPSIGN;
				end else begin
					p_phase = dtf_pkg::PH_STOP;
				end
			end
			dtf_pkg::PH_EXPSIGN: begin
				if (c == "-") begin
					p_eneg = 1;
					p_phase = dtf_pkg::PH_EXPDIG;
				end else if (c == "+") begin
					p_phase = dtf_pkg::PH_EXPDIG;
				end else if (is_digit(c)) begin
					add_exp_digit(c);
					p_phase = dtf_pkg::PH_EXPDIG;
				end else begin
					p_phase = dtf_pkg::PH_STOP;
				end
			end
			dtf_pkg::PH_EXPDIG: begin
				if (is_digit(c))
					add_exp_digit(c);
				else
					p_phase = dtf_pkg::PH_STOP;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] parsed_float();
		logic [31:0] r, pw;
		if (p_phase == dtf_pkg::PH_BLANK || p_phase == dtf_pkg::PH_SIGNED)
			return dtf_pkg::F_ZERO;
		r = f_add(p_mant, f_div(p_frac, p_divr));
		if (p_eseen) begin
			pw = dtf_pkg::F_ONE;
			for (int i = 0; i < int'(p_ecnt); i++)
				pw = f_mul(pw, dtf_pkg::F_TEN);
			r = p_eneg ? f_div(r, pw) : f_mul(r, pw);
		end
		if (f_nan(r))
			return dtf_pkg::F_QNAN;
		if (p_neg)
			r[31] = ~r[31];
		return r;
	endfunction

	function automatic void predict(req_t r);
		logic [31:0] v;
		if (r.has_chr)
			parse_char(r.chr);
		if (r.is_last) begin
			v = parsed_float();
			float_q.push_back(r.fixed ? r.fixed_val : v);
			parser_clear();
		end
	endfunction

	// ---- stimulus generation ----
	function automatic void push_text(string txt, bit fixed, logic [31:0] val);
		req_t r;
		r.fixed = fixed;
		r.fixed_val = val;
		r.has_chr = 1;
		if (txt.len() == 0) begin
			r.chr = 0;
			r.has_chr = 0;
			r.is_last = 1;
			req_q.push_back(r);
			return;
		end
		for (int i = 0; i < txt.len(); i++) begin
			r.chr = txt[i];
			r.is_last = (i == txt.len() - 1);
			req_q.push_back(r);
		end
	endfunction

	function automatic int digit_count();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 45) : $urandom_range(0, 4);
	endfunction

	function automatic void push_random_text();
		logic [7:0] s[$];
		logic [7:0] blanks[4] = '{" ", 8'd13, 8'd10, 8'd9};
		req_t r;
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n)
				s.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 2))
				s.push_back(blanks[$urandom_range(0, 3)]);
			case ($urandom_range(0, 2))
				1: s.push_back("-");
				2: s.push_back("+");
				default: ;
			endcase
			repeat (digit_count())
				s.push_back(8'("0" + $urandom_range(0, 9)));
			if ($urandom_range(0, 1)) begin
				s.push_back(".");
				repeat (digit_count())
					s.push_back(8'("0" + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 4) < 2) begin
				s.push_back($urandom_range(0, 1) ? "e" : "E");
				case ($urandom_range(0, 2))
					1: s.push_back("-");
					2: s.push_back("+");
					default: ;
				endcase
				repeat ($urandom_range(0, 3))
					s.push_back(8'("0" + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 7) == 0)
				s.insert($urandom_range(0, s.size()), 8'($urandom));
		end
		if (s.size() == 0 || $urandom_range(0, 9) == 0)
			s.push_back(8'h00);
		r.fixed = 0;
		r.fixed_val = 0;
		foreach (s[i]) begin
			if ($urandom_range(0, 29) == 0) begin
				r.chr = 8'($urandom);
				r.has_chr = 0;
				r.is_last = 0;
				req_q.push_back(r);
			end
			r.chr = s[i];
			r.is_last = (i == s.size() - 1);
			r.has_chr = !(r.is_last && s[i] == 8'h00 && $urandom_range(0, 1));
			req_q.push_back(r);
		end
	endfunction

	// ---- drivers ----
	task automatic send_req(input req_t r);
		s_tvalid <= 1;
		s_tdata <= r.chr;
		s_tuser <= r.has_chr;
		s_tlast <= r.is_last;
		forever begin
			@(negedge clk);
			if (s_tready)
				break;
		end
		predict(r);
		@(posedge clk);
	endtask

	task automatic send_all();
		int burst, gap;
		burst = $urandom_range(1, 24);
		while (req_q.size() > 0) begin
			send_req(req_q.pop_front());
			burst--;
			if (burst <= 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 24);
			end
		end
		s_tvalid <= 0;
	endtask

	initial begin
		int pattern_cnt;
		m_tready = 0;
		pattern_cnt = 0;
		forever begin
			@(posedge clk);
			pattern_cnt++;
			if (stall_req) begin
				stall_req = 0;
				m_tready <= 0;
				repeat (600) @(posedge clk);
			end else begin
				case ((pattern_cnt / 64) % 3)
					0: m_tready <= 1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result checker and watchdog
	always @(negedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (m_tvalid && m_tready) begin
				if (float_q.size() == 0) begin
					$error("value_bits: no request expected, got %h", m_tdata);
					mismatch_cnt++;
				end else begin
					want = float_q.pop_front();
					if (m_tdata !== want) begin
						$error("value_bits: expected %h, got %h", want, m_tdata);
						mismatch_cnt++;
					end
				end
			end
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[9] = '{
			'{"", 1, dtf_pkg::F_ZERO},
			'{"-", 1, dtf_pkg::F_ZERO},
			'{" \t\r\n+", 1, dtf_pkg::F_ZERO},
			'{"-0", 1, 32'h8000_0000},
			'{"7e", 0, 0},
			'{"9e99", 1, dtf_pkg::F_INF},
			'{"0e40", 1, dtf_pkg::F_QNAN},
			'{"1.25E-1", 0, 0},
			'{"x9", 1, dtf_pkg::F_ZERO}
		};
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		s_tlast = 0;
		arst_n = 0;
		parser_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			push_text(rows[i].txt, rows[i].fixed, rows[i].val);
		send_all();

		// drain, then hold the receiver off while the sender keeps going
		while (float_q.size() > 0)
			@(posedge clk);
		stall_req = 1;
		while (req_q.size() < RAND_REQS)
			push_random_text();
		send_all();

		while (float_q.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_fpu.sv
hw/rtl/dtf_dp.sv
hw/rtl/dtf_ctrl.sv
hw/rtl/decimal_text_to_float32_unit.sv
test/tb.sv
